// File: hw/rtl/swm_pkg.sv
// Shared types and constants for the sliding window median filter.
// Used by swm_cell, swm_seq and sliding_window_median; depends on nothing.
`default_nettype none

package swm_pkg;

  // Built defaults for the top level parameters.
  localparam int MAX_WINDOW_DEF   = 64;
  localparam int SAMPLE_WIDTH_DEF = 32;

  // Configuration port geometry.
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;
  localparam int WS_W    = 7;
  localparam int WS_RESET = 3;

  // Register index as decoded from paddr[2].
  localparam logic REG_WINDOW_SIZE = 1'b0;

  // Per-cycle commands from the sequencer to every cell of the chain.
  typedef struct packed {
    logic shift;   // shift a new sample into the window
    logic load;    // copy each window value into its probe slot
    logic rotate;  // move the probes one cell toward cell 0, wrapping at k-1
    logic count;   // rank comparison at the probe's current cell
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_COUNT,
    ST_SCAN,
    ST_PUSH
  } seq_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/swm_cell.sv
// One cell of the median chain: a window slot plus a circulating probe slot.
// Depends on swm_pkg for the control struct.
`default_nettype none

module swm_cell #(
  parameter int IDX = 0,
  parameter int SW  = 32,
  parameter int KW  = 7,
  parameter int IW  = 6
) (
  input  wire                   clk,
  input  swm_pkg::cell_ctrl_t   ctrl,
  input  wire        [KW-1:0]   k,
  input  wire signed [SW-1:0]   win_in,
  output logic signed [SW-1:0]  win_out,
  input  wire signed [SW-1:0]   nb_val,
  input  wire        [IW-1:0]   nb_idx,
  input  wire        [IW-1:0]   nb_cnt,
  input  wire signed [SW-1:0]   wrap_val,
  input  wire        [IW-1:0]   wrap_idx,
  input  wire        [IW-1:0]   wrap_cnt,
  output logic signed [SW-1:0]  prb_val,
  output logic       [IW-1:0]   prb_idx,
  output logic       [IW-1:0]   prb_cnt
);

  logic signed [SW-1:0] win_r;
  logic signed [SW-1:0] prb_val_r;
  logic        [IW-1:0] prb_idx_r;
  logic        [IW-1:0] prb_cnt_r;
  logic                 active;
  logic                 last;
  logic                 ahead;

  assign active = KW'(IDX) < k;
  assign last   = KW'(IDX) == (k - KW'(1));

  // The window entry here ranks ahead of the probe: smaller, or equal and older.
  assign ahead = active && ((win_r < prb_val_r) ||
                            ((win_r == prb_val_r) && (IW'(IDX) > prb_idx_r)));

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      win_r <= win_in;
    end
    if (ctrl.load) begin
      prb_val_r <= win_r;
      prb_idx_r <= IW'(IDX);
      prb_cnt_r <= '0;
    end else if (ctrl.rotate) begin
      if (last) begin
        prb_val_r <= wrap_val;
        prb_idx_r <= wrap_idx;
        prb_cnt_r <= wrap_cnt;
      end else begin
        prb_val_r <= nb_val;
        prb_idx_r <= nb_idx;
        prb_cnt_r <= nb_cnt;
      end
    end
  end

  assign win_out = win_r;
  assign prb_val = prb_val_r;
  assign prb_idx = prb_idx_r;
  assign prb_cnt = (ctrl.count && ahead) ? prb_cnt_r + IW'(1) : prb_cnt_r;

endmodule

`default_nettype wire

// File: hw/rtl/swm_seq.sv
// Sequencer of the median chain: fill count, phase control and step counter.
// Depends on swm_pkg for the state enum and the cell control struct.
`default_nettype none

module swm_seq #(
  parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF,
  parameter int KW         = 7
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire [KW-1:0]         k,
  input  wire                  in_acc,
  input  wire                  match,
  input  wire                  out_free,
  output swm_pkg::cell_ctrl_t  ctrl,
  output logic                 busy,
  output logic                 capture,
  output logic                 push
);

  swm_pkg::seq_state_t state_r, state_nxt;
  logic [KW-1:0] fill_r, fill_nxt;
  logic [KW-1:0] step_r, step_nxt;
  logic [KW-1:0] fill_inc;
  logic [KW-1:0] km1;
  logic          hit;

  assign km1      = k - KW'(1);
  assign fill_inc = (fill_r < KW'(MAX_WINDOW)) ? fill_r + KW'(1) : fill_r;
  assign hit      = fill_inc >= k;

  always_comb begin
    fill_nxt = fill_r;
    if (in_acc) begin
      fill_nxt = hit ? km1 : fill_inc;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      swm_pkg::ST_IDLE:  if (in_acc && hit) state_nxt = swm_pkg::ST_LOAD;
      swm_pkg::ST_LOAD:  state_nxt = swm_pkg::ST_COUNT;
      swm_pkg::ST_COUNT: if (step_r == km1) state_nxt = swm_pkg::ST_SCAN;
      swm_pkg::ST_SCAN:  if (match) state_nxt = swm_pkg::ST_PUSH;
      swm_pkg::ST_PUSH:  if (out_free) state_nxt = swm_pkg::ST_IDLE;
      default:           state_nxt = swm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl     = '0;
    busy     = 1'b1;
    capture  = 1'b0;
    push     = 1'b0;
    step_nxt = step_r;
    case (state_r)
      swm_pkg::ST_IDLE: begin
        busy       = 1'b0;
        ctrl.shift = in_acc;
      end
      swm_pkg::ST_LOAD: begin
        ctrl.load = 1'b1;
        step_nxt  = '0;
      end
      swm_pkg::ST_COUNT: begin
        ctrl.count  = 1'b1;
        ctrl.rotate = 1'b1;
        step_nxt    = step_r + KW'(1);
      end
      swm_pkg::ST_SCAN: begin
        ctrl.rotate = !match;
        capture     = match;
      end
      swm_pkg::ST_PUSH: begin
        push = out_free;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swm_pkg::ST_IDLE;
      fill_r  <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/sliding_window_median.sv
// Top level of the sliding window lower-median filter.
// Depends on swm_pkg, swm_cell and swm_seq.
//
// Usage: samples arrive on the in_ channel (in_valid, in_stall, in_sample) and
// medians leave on the out_ channel (out_valid, out_stall, out_median). An
// item moves at a rising edge where valid is high and stall is low. The last
// window_size samples are held in a chain of cells, newest in cell 0. An item
// that leaves the window short of window_size samples gives no result, and the
// next item can follow in the next cycle. An item that completes the window
// gives the lower median of the newest window_size samples, after which the
// window counts as one short again.
// With k the effective window size, a completing item passes the load step,
// a ranking pass over all k cells, a scan until the probe in cell 0 holds
// the target rank, and the push state into the output register. The input
// is stalled meanwhile, so the next item is taken only once the sequencer
// is back in idle. Each probe visits one cell per cycle and must pass all k
// cells to know its rank. Reset empties the window and sets window_size to
// 3, with no clearing pass. A result stalled in the output register does
// not hold up the input; only the next result waits for it in the push
// state. window_size (APB register 0) may be written only when idle.
`default_nettype none

module sliding_window_median #(
  parameter int MAX_WINDOW   = swm_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  // Sample input channel.
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire signed [SAMPLE_WIDTH-1:0] in_sample,
  // Median output channel.
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_median,
  // Configuration port.
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire [swm_pkg::CFG_AW-1:0]     paddr,
  input  wire [swm_pkg::CFG_DW-1:0]     pwdata,
  output logic [swm_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready
);

  // KW holds a count from 0 to MAX_WINDOW, IW an entry index or a rank.
  localparam int KW = $clog2(MAX_WINDOW + 1);
  localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int EW = (KW > swm_pkg::WS_W) ? KW : swm_pkg::WS_W;

  logic [swm_pkg::WS_W-1:0] ws_r;
  logic [EW-1:0]            ws_ext;
  logic [KW-1:0]            k_eff;
  logic [KW-1:0]            km1;
  logic [IW-1:0]            target;

  // Configuration register. pready is tied high, so the access phase never
  // waits. Only paddr[2] selects the register.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r <= swm_pkg::WS_W'(swm_pkg::WS_RESET);
    end else if (psel && penable && pwrite && (paddr[2] == swm_pkg::REG_WINDOW_SIZE)) begin
      ws_r <= pwdata[swm_pkg::WS_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == swm_pkg::REG_WINDOW_SIZE) begin
      prdata = swm_pkg::CFG_DW'(ws_r);
    end
  end

  // Effective window size: a size of zero acts as one, and a size above the
  // built depth is clipped to it. The target rank is (k-1)/2.
  assign ws_ext = EW'(ws_r);
  always_comb begin
    if (ws_r == '0) begin
      k_eff = KW'(1);
    end else if (ws_ext > EW'(MAX_WINDOW)) begin
      k_eff = KW'(MAX_WINDOW);
    end else begin
      k_eff = KW'(ws_ext);
    end
  end
  assign km1    = k_eff - KW'(1);
  assign target = IW'(km1 >> 1);

  // Sequencer.
  swm_pkg::cell_ctrl_t ctrl;
  logic busy, capture, push, match, out_free, in_acc;

  assign in_stall = busy;
  assign in_acc   = in_valid && !busy;

  swm_seq #(
    .MAX_WINDOW (MAX_WINDOW),
    .KW         (KW)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .k        (k_eff),
    .in_acc   (in_acc),
    .match    (match),
    .out_free (out_free),
    .ctrl     (ctrl),
    .busy     (busy),
    .capture  (capture),
    .push     (push)
  );

  // Cell chain. The window shifts from cell 0 upward; probes move toward
  // cell 0 and the probe leaving cell 0 re-enters at cell k-1. Each probe
  // carries its value, its home index and the number of window entries
  // found to rank ahead of it so far.
  logic signed [SAMPLE_WIDTH-1:0] win_w [MAX_WINDOW];
  logic signed [SAMPLE_WIDTH-1:0] pv_w  [MAX_WINDOW];
  logic        [IW-1:0]           pi_w  [MAX_WINDOW];
  logic        [IW-1:0]           pc_w  [MAX_WINDOW];

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic signed [SAMPLE_WIDTH-1:0] w_in;
    logic signed [SAMPLE_WIDTH-1:0] n_val;
    logic        [IW-1:0]           n_idx;
    logic        [IW-1:0]           n_cnt;

    if (i == 0) begin : g_first
      assign w_in = in_sample;
    end else begin : g_inner
      assign w_in = win_w[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_end
      assign n_val = pv_w[0];
      assign n_idx = pi_w[0];
      assign n_cnt = pc_w[0];
    end else begin : g_mid
      assign n_val = pv_w[i+1];
      assign n_idx = pi_w[i+1];
      assign n_cnt = pc_w[i+1];
    end

    swm_cell #(
      .IDX (i),
      .SW  (SAMPLE_WIDTH),
      .KW  (KW),
      .IW  (IW)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .k        (k_eff),
      .win_in   (w_in),
      .win_out  (win_w[i]),
      .nb_val   (n_val),
      .nb_idx   (n_idx),
      .nb_cnt   (n_cnt),
      .wrap_val (pv_w[0]),
      .wrap_idx (pi_w[0]),
      .wrap_cnt (pc_w[0]),
      .prb_val  (pv_w[i]),
      .prb_idx  (pi_w[i]),
      .prb_cnt  (pc_w[i])
    );
  end

  // During the scan no counting takes place, so cell 0 shows the finished
  // rank of the probe sitting there. Exactly one probe has the target rank.
  assign match = (pc_w[0] == target);

  logic signed [SAMPLE_WIDTH-1:0] med_r;

  always_ff @(posedge clk) begin
    if (capture) begin
      med_r <= pv_w[0];
    end
  end

  // Output register.
  logic                           out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] out_median_r;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (push) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_median_r <= med_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_median = out_median_r;

endmodule

`default_nettype wire

// File: tb/sliding_window_median_tb.sv
// Self-checking testbench for the sliding window lower-median filter.
// Depends on swm_pkg and sliding_window_median; predicts every median in-house.
`timescale 1ns / 100ps

module sliding_window_median_tb;
  import swm_pkg::*;

  localparam int WIN_MAX = MAX_WINDOW_DEF;
  localparam int SW      = SAMPLE_WIDTH_DEF;

  // This covers the longest pass of a completing item through the chain for
  // the largest window, with a little margin before the register is touched.
  localparam int SETTLE_CYCLES = 2 * WIN_MAX + 12;

  // Cycles without any transfer on any port before the run is declared hung.
  // It sits far above the chain latency, the settle pause and any plausible
  // random stall or idle stretch.
  localparam int QUIET_LIMIT = 5000;

  // Byte addresses of the configuration registers; only index 0 exists.
  localparam logic [CFG_AW-1:0] ADDR_WINDOW_SIZE = {REG_WINDOW_SIZE, 2'b00};
  localparam logic [CFG_AW-1:0] ADDR_UNUSED      = 3'd4;

  localparam int NUM_PHASES = 16;

  typedef logic signed [SW-1:0] sample_t;
  typedef logic [WS_W-1:0]      wsize_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  sample_t             in_sample = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  sample_t             out_median;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CFG_AW-1:0]   paddr = '0;
  logic [CFG_DW-1:0]   pwdata = '0;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  // Samples waiting to be offered, and medians the filter still owes us.
  sample_t pending_samples[$];
  sample_t median_q[$];

  // Our own copy of the filter state: newest held sample at the front.
  wsize_t  win_size_reg = wsize_t'(WS_RESET);
  sample_t held_q[$];
  int      held_count = 0;

  int mismatch_count = 0;
  int quiet_cycles = 0;
  int sender_idle_pct = 0;
  int rcv_stall_pct = 0;

  sliding_window_median uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_median (out_median),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Append one sample to the tail of the queue of items still to be offered.
  function automatic void add_pending(sample_t s);
    pending_samples.insert(pending_samples.size(), s);
  endfunction

  // A register value of zero behaves as a window of one, and anything above
  // the built depth saturates to that depth.
  function automatic int effective_window();
    int k;
    k = int'(win_size_reg);
    if (k == 0) begin
      k = 1;
    end
    if (k > WIN_MAX) begin
      k = WIN_MAX;
    end
    return k;
  endfunction

  // Shift one accepted sample into the held window. When the window is full
  // the lower median of the newest k samples is queued, and the window then
  // counts as one short again. Ties need no arrival ordering here because
  // equal values give the same median value whichever one is picked.
  function automatic void shift_in_sample(sample_t s);
    sample_t ranked[WIN_MAX];
    sample_t v;
    int      k;
    int      j;
    held_q.push_front(s);
    if (held_q.size() > WIN_MAX) begin
      void'(held_q.pop_back());
    end
    if (held_count < WIN_MAX) begin
      held_count++;
    end
    k = effective_window();
    if (held_count >= k) begin
      // Insertion sort of the newest k samples, signed order.
      for (int i = 0; i < k; i++) begin
        v = held_q[i];
        j = i;
        while (j > 0 && ranked[j-1] > v) begin
          ranked[j] = ranked[j-1];
          j--;
        end
        ranked[j] = v;
      end
      median_q.insert(median_q.size(), ranked[(k - 1) / 2]);
      held_count = k - 1;
    end
  endfunction

  // Mix of full-range values, a narrow band that forces many equal values,
  // and the two extremes with their neighbors.
  function automatic sample_t random_sample();
    sample_t s;
    case ($urandom_range(9))
      0, 1, 2, 3: s = sample_t'($urandom);
      4, 5, 6:    s = sample_t'($urandom_range(8)) - sample_t'(4);
      7:          s = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: begin
        s = $urandom_range(1) ? 32'sh7ffffff0 : 32'sh80000000;
        s = s + sample_t'($urandom_range(15));
      end
    endcase
    return s;
  endfunction

  // APB write: setup cycle, then access cycle. The register takes the value
  // at the edge where psel, penable, pwrite and pready are all high.
  task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // Writes to any other index are dropped by the block.
    if (addr == ADDR_WINDOW_SIZE) begin
      win_size_reg = data[WS_W-1:0];
    end
  endtask

  // Wait until every queued sample has gone in and every predicted median has
  // come out, then give the chain time to finish an item that gives no
  // result. Only after this is a register write safe.
  task automatic wait_for_quiet();
    @(posedge clk);
    while (pending_samples.size() != 0 || in_valid || median_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Sample driver. A new item is offered only once the current one has been
  // taken, so a stalled payload never changes. Each item is predicted at the
  // edge where it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        shift_in_sample(in_sample);
      end
      if (!in_valid || !in_stall) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_sample <= pending_samples.pop_front();
          in_valid  <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Median monitor, random back-pressure and the hang watchdog.
  always @(posedge clk) begin : median_monitor
    sample_t want;
    if (rst_n) begin
      out_stall <= ($urandom_range(99) < rcv_stall_pct);
      if (out_valid && !out_stall) begin
        if (median_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected median %0d with nothing expected", out_median);
          end
        end else begin
          want = median_q.pop_front();
          if (out_median !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("median mismatch: expected %0d, got %0d", want, out_median);
            end
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("sliding_window_median test failed");
        $finish;
      end
    end
  end

  // Stimulus sequence: a directed part that exercises the reset window size,
  // the extremes, window changes with samples held, a zero window and a write
  // to an unused index; then random phases over a spread of window sizes,
  // rotating through the four idle/stall profiles.
  initial begin : stimulus
    sample_t corners[10];
    wsize_t  size_plan[NUM_PHASES];
    int      k;
    int      n;

    corners = '{32'sh80000000, 32'sh7fffffff, 32'sh0, -32'sh1, 32'sh1,
                32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh5, 32'sh5};
    // Saturating and zero values, large windows, and many small ones.
    size_plan = '{7'd127, 7'd4, 7'd1, 7'd7, 7'd64, 7'd2, 7'd9, 7'd3,
                  7'd33, 7'd6, 7'd5, 7'd8, 7'd0, 7'd15, 7'd3, 7'd10};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Window of three straight out of reset, fed the extreme values.
    foreach (corners[i]) begin
      add_pending(corners[i]);
    end
    wait_for_quiet();

    // Raise the window while two samples are held: they must count toward it.
    cfg_write(ADDR_WINDOW_SIZE, 32'd5);
    add_pending(32'sh3);
    add_pending(-32'sh3);
    add_pending(32'sh3);
    add_pending(32'sh80000000);
    wait_for_quiet();

    // Lower the window while four samples are held.
    cfg_write(ADDR_WINDOW_SIZE, 32'd2);
    add_pending(32'sh7fffffff);
    add_pending(-32'sh3);
    wait_for_quiet();

    // A zero window acts as a window of one.
    cfg_write(ADDR_WINDOW_SIZE, 32'd0);
    add_pending(-32'sh7);
    add_pending(32'sh80000000);
    add_pending(32'sh7fffffff);
    wait_for_quiet();

    // A write to an index with no register must leave the window alone.
    cfg_write(ADDR_UNUSED, 32'd9);
    add_pending(32'sh11);
    add_pending(-32'sh11);
    wait_for_quiet();

    for (int p = 0; p < NUM_PHASES; p++) begin
      // Upper data bits are noise; only the low seven bits are the register.
      cfg_write(ADDR_WINDOW_SIZE, ($urandom & ~32'h7f) | CFG_DW'(size_plan[p]));
      case (p % 4)
        0: begin
          sender_idle_pct = 0;
          rcv_stall_pct   = 0;
        end
        1: begin
          sender_idle_pct = 80;
          rcv_stall_pct   = 0;
        end
        2: begin
          sender_idle_pct = 0;
          rcv_stall_pct   = 80;
        end
        default: begin
          sender_idle_pct = 30;
          rcv_stall_pct   = 30;
        end
      endcase
      k = effective_window();
      n = (k >= 32) ? k + 40 : 70;
      for (int i = 0; i < n; i++) begin
        add_pending(random_sample());
      end
      wait_for_quiet();
    end

    sender_idle_pct = 0;
    rcv_stall_pct   = 0;
    if (mismatch_count == 0 && median_q.size() == 0) begin
      $display("sliding_window_median test passed");
    end else begin
      $display("sliding_window_median test failed");
    end
    $finish;
  end

endmodule
